// ===== design/mcs_pkg.sv =====
// Shared constants, types and elaboration-time tables of the metronome click sequencer.
package mcs_pkg;

	localparam int MAX_STEPS       = 16;
	localparam int CLICK_FRAMES    = 2048;
	localparam int SINE_TABLE_BITS = 10;

	localparam int STEP_BITS   = 3;
	localparam int PATTERN_W   = 48;
	localparam int STEP_IDX_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int SECONDS_PER_MINUTE = 60;

	localparam int POS_W   = $clog2(CLICK_FRAMES + 1);
	localparam int ENV_AW  = $clog2(CLICK_FRAMES);
	localparam int SINE_AW = SINE_TABLE_BITS - 2;
	localparam int SINE_Q  = 1 << SINE_AW;

	localparam int DIV_W      = 44;
	localparam int DIVISOR_W  = 18;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_BPM     = 2'd0;
	localparam reg_index_t REG_RATE    = 2'd1;
	localparam reg_index_t REG_PATTERN = 2'd2;
	localparam reg_index_t REG_COUNT   = 2'd3;

	localparam logic [8:0]  BPM_MIN  = 9'd20;
	localparam logic [8:0]  BPM_MAX  = 9'd300;
	localparam logic [17:0] RATE_MIN = 18'd8000;
	localparam logic [17:0] RATE_MAX = 18'd192000;

	typedef logic [1:0] step_kind_t;
	localparam step_kind_t KIND_NORMAL = 2'd0;
	localparam step_kind_t KIND_ACCENT = 2'd1;
	localparam step_kind_t KIND_MUTE   = 2'd2;

	localparam logic [10:0] FREQ_RIGHT  = 11'd1320;
	localparam logic [10:0] FREQ_LEFT   = 11'd1120;
	localparam logic [10:0] FREQ_ACCENT = 11'd440;
	localparam logic [14:0] AMP_ACCENT  = 15'd26214;
	localparam logic [14:0] AMP_NORMAL  = 15'd16384;

	typedef struct packed {
		logic        restart;
		logic        beat;
		logic        accent;
		logic        left;
		logic        mute;
		logic [31:0] beat_total;
	} click_cmd_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_W-1:0]     quotient;
		logic [DIVISOR_W-1:0] remainder;
	} div_rsp_t;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] EXP_INT_Q30 [7] = '{
		64'd1073741824, 64'd395007542, 64'd145315153, 64'd53458457,
		64'd19666267, 64'd7234815, 64'd2661540
	};

	typedef logic [14:0] sine_tbl_t [SINE_Q];
	typedef logic [30:0] env_tbl_t [CLICK_FRAMES];

	// Entry k-1 holds the quarter-wave magnitude at step k; step zero is zero.
	function automatic sine_tbl_t build_sine();
		sine_tbl_t   tbl;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] b;
		logic [63:0] s;
		logic [63:0] r;
		for (int k = 1; k <= SINE_Q; k++) begin
			t  = (64'(k) * HALF_PI_Q30) >> SINE_AW;
			t2 = (t * t) >> 30;
			b  = Q30_ONE - t2 / 72;
			b  = Q30_ONE - (((t2 / 42) * b) >> 30);
			b  = Q30_ONE - (((t2 / 20) * b) >> 30);
			b  = Q30_ONE - (((t2 / 6) * b) >> 30);
			s  = (t * b) >> 30;
			r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			tbl[k-1] = (r > 64'd32767) ? 15'd32767 : r[14:0];
		end
		return tbl;
	endfunction

	// Decay exp(-7n/N) in Q30: integer part from a short table, fraction by series.
	function automatic env_tbl_t build_env();
		env_tbl_t    tbl;
		logic [63:0] num;
		logic [63:0] ip;
		logic [63:0] f;
		logic [63:0] b;
		logic [63:0] e;
		for (int n = 0; n < CLICK_FRAMES; n++) begin
			num = 64'd7 * 64'(n);
			ip  = num / CLICK_FRAMES;
			f   = ((num % CLICK_FRAMES) << 30) / CLICK_FRAMES;
			b   = Q30_ONE;
			b   = Q30_ONE - ((f * b) >> 30) / 10;
			b   = Q30_ONE - ((f * b) >> 30) / 9;
			b   = Q30_ONE - ((f * b) >> 30) / 8;
			b   = Q30_ONE - ((f * b) >> 30) / 7;
			b   = Q30_ONE - ((f * b) >> 30) / 6;
			b   = Q30_ONE - ((f * b) >> 30) / 5;
			b   = Q30_ONE - ((f * b) >> 30) / 4;
			b   = Q30_ONE - ((f * b) >> 30) / 3;
			b   = Q30_ONE - ((f * b) >> 30) / 2;
			b   = Q30_ONE - ((f * b) >> 30);
			if (ip > 64'd6) begin
				ip = 64'd6;
			end
			e = (b * EXP_INT_Q30[ip[2:0]]) >> 30;
			tbl[n] = e[30:0];
		end
		return tbl;
	endfunction

endpackage

// ===== design/mcs_if.sv =====
// Handshake channels for incoming frames and outgoing click samples.
interface mcs_frame_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, restart, input ready);
	modport sink (input valid, restart, output ready);
endinterface

interface mcs_click_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               beat_started;
	logic [31:0]        beat_total;

	modport source (output valid, sample, beat_started, beat_total, input ready);
	modport sink (input valid, sample, beat_started, beat_total, output ready);
endinterface

// ===== design/mcs_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module mcs_div (
	input  logic             clk,
	input  logic             arst_n,
	input  mcs_pkg::div_req_t req,
	output mcs_pkg::div_rsp_t rsp
);
	import mcs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;
endmodule

// ===== design/mcs_front.sv =====
// Front end: takes frames, tracks the beat time line and picks the pattern step.
module mcs_front (
	input  logic                clk,
	input  logic                arst_n,
	mcs_frame_if.sink           frames,
	input  logic [8:0]          beats_per_minute,
	input  logic [17:0]         sample_rate,
	input  logic [47:0]         step_pattern,
	input  logic [4:0]          step_count,
	input  logic                queue_room,
	output logic                push,
	output mcs_pkg::click_cmd_t cmd
);
	import mcs_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_EVAL = 4'b0010,
		F_MOD  = 4'b0100,
		F_PER  = 4'b1000
	} front_state_t;

	localparam int SHAMT_W = 8;

	front_state_t    state_q;
	logic [39:0]     frame_q;
	logic [55:0]     next_beat_q;
	logic [31:0]     step_q;
	logic [31:0]     beats_q;
	logic            restart_q;
	logic [2:0]      code_q;

	logic            accept;
	logic [55:0]     diff;
	logic            beat_due;
	logic            use_mod;
	logic [23:0]     rate60;
	logic [DIV_W-1:0] period_dividend;
	logic [SHAMT_W-1:0] shamt;
	logic [PATTERN_W-1:0] pattern_shift;
	div_req_t        div_req;
	div_rsp_t        div_rsp;

	mcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign frames.ready = (state_q == F_IDLE) && queue_room;
	assign accept       = frames.valid && frames.ready;

	// The beat is due once the frame time has reached the scheduled beat time.
	assign diff     = {frame_q, 16'd0} - next_beat_q;
	assign beat_due = !diff[55];

	assign rate60          = 24'(sample_rate) * 24'(SECONDS_PER_MINUTE);
	assign period_dividend = DIV_W'({rate60, 16'd0});
	assign use_mod         = (state_q == F_EVAL) && (step_count != 5'd0);

	assign shamt = SHAMT_W'(div_rsp.remainder[STEP_IDX_W-1:0]) * SHAMT_W'(STEP_BITS);
	assign pattern_shift = step_pattern >> shamt;

	always_comb begin
		div_req.start    = ((state_q == F_EVAL) && beat_due) ||
			((state_q == F_MOD) && div_rsp.done);
		div_req.dividend = use_mod ? DIV_W'(step_q) : period_dividend;
		div_req.divisor  = use_mod ? DIVISOR_W'(step_count) : DIVISOR_W'(beats_per_minute);
	end

	always_comb begin
		push = ((state_q == F_EVAL) && !beat_due) || ((state_q == F_PER) && div_rsp.done);
		cmd.restart    = restart_q;
		cmd.beat       = (state_q == F_PER);
		cmd.accent     = (code_q[1:0] == KIND_ACCENT);
		cmd.mute       = (code_q[1:0] == KIND_MUTE);
		cmd.left       = code_q[2];
		cmd.beat_total = (state_q == F_PER) ? beats_q + 32'd1 : beats_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			frame_q     <= '0;
			next_beat_q <= '0;
			step_q      <= '0;
			beats_q     <= '0;
			restart_q   <= 1'b0;
			code_q      <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						restart_q <= frames.restart;
						if (frames.restart) begin
							frame_q     <= '0;
							next_beat_q <= '0;
							step_q      <= '0;
							beats_q     <= '0;
						end
						state_q <= F_EVAL;
					end
				end
				F_EVAL: begin
					if (beat_due) begin
						if (step_count != 5'd0) begin
							state_q <= F_MOD;
						end else begin
							code_q  <= '0;
							state_q <= F_PER;
						end
					end else begin
						frame_q <= frame_q + 40'd1;
						state_q <= F_IDLE;
					end
				end
				F_MOD: begin
					if (div_rsp.done) begin
						code_q  <= pattern_shift[STEP_BITS-1:0];
						state_q <= F_PER;
					end
				end
				F_PER: begin
					if (div_rsp.done) begin
						next_beat_q <= next_beat_q + 56'(div_rsp.quotient);
						step_q      <= step_q + 32'd1;
						beats_q     <= beats_q + 32'd1;
						frame_q     <= frame_q + 40'd1;
						state_q     <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q == F_EVAL)
		else $error("accepted frame did not enter evaluation");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> beats_q == $past(cmd.beat_total))
		else $error("beat counter disagrees with the pushed transaction");
`endif
endmodule

// ===== design/mcs_queue.sv =====
// Short command queue between the front end and the click generator.
module mcs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mcs_pkg::click_cmd_t push_cmd,
	input  logic                pop,
	output mcs_pkg::click_cmd_t pop_cmd,
	output logic                room,
	output logic                avail
);
	import mcs_pkg::*;

	click_cmd_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign room    = count_q != QCNT_W'(QUEUE_DEPTH);
	assign avail   = count_q != '0;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) push |-> room || pop)
		else $error("push into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> avail)
		else $error("pop from an empty queue");
`endif
endmodule

// ===== design/mcs_back.sv =====
// Click generator: envelope, sine and phase accumulator for each frame while a click sounds.
module mcs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [17:0]         sample_rate,
	input  logic                cmd_valid,
	input  mcs_pkg::click_cmd_t cmd,
	output logic                pop,
	mcs_click_if.source         clicks
);
	import mcs_pkg::*;

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_LOOK = 6'b000010,
		B_GAIN = 6'b000100,
		B_MAG  = 6'b001000,
		B_WAIT = 6'b010000,
		B_DONE = 6'b100000
	} back_state_t;

	localparam sine_tbl_t SINE_TBL = build_sine();
	localparam env_tbl_t  ENV_TBL  = build_env();

	back_state_t        state_q;
	logic [POS_W-1:0]   pos_q;
	logic               accent_q;
	logic               left_q;
	logic [31:0]        phase_q;
	logic               beat_q;
	logic [31:0]        total_q;
	logic [30:0]        env_q;
	logic [14:0]        smag_q;
	logic               neg_q;
	logic [29:0]        gain_q;
	logic [14:0]        mag_q;
	logic signed [15:0] result_q;
	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic               out_beat_q;
	logic [31:0]        out_total_q;

	logic                     clicking;
	logic                     load_out;
	logic [SINE_TABLE_BITS-1:0] sidx;
	logic [SINE_AW:0]         kk;
	logic [SINE_AW:0]         kk_m1;
	logic [14:0]              smag_c;
	logic [10:0]              freq;
	logic [14:0]              amp;
	logic [45:0]              gain_full;
	logic [45:0]              mag_full;
	logic [15:0]              mag_ext;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	mcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pop      = (state_q == B_IDLE) && cmd_valid;
	assign clicking = pos_q < POS_W'(CLICK_FRAMES);
	assign load_out = (state_q == B_DONE) && (!out_valid_q || clicks.ready);

	// Odd quadrants mirror the quarter wave; the upper half of the cycle is negative.
	assign sidx   = phase_q[31 -: SINE_TABLE_BITS];
	assign kk     = sidx[SINE_TABLE_BITS-2] ?
		((SINE_AW+1)'(SINE_Q) - {1'b0, sidx[SINE_AW-1:0]}) : {1'b0, sidx[SINE_AW-1:0]};
	assign kk_m1  = kk - 1'b1;
	assign smag_c = (kk == '0) ? 15'd0 : SINE_TBL[kk_m1[SINE_AW-1:0]];

	assign freq = (left_q ? FREQ_LEFT : FREQ_RIGHT) + (accent_q ? FREQ_ACCENT : 11'd0);
	assign amp  = accent_q ? AMP_ACCENT : AMP_NORMAL;

	assign gain_full = 46'(amp) * 46'(env_q);
	assign mag_full  = 46'(smag_q) * 46'(gain_q) + (46'd1 << 29);
	assign mag_ext   = {1'b0, mag_q};

	always_comb begin
		div_req.start    = (state_q == B_LOOK) && clicking;
		div_req.dividend = DIV_W'({freq, 32'd0}) + DIV_W'(sample_rate >> 1);
		div_req.divisor  = sample_rate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			pos_q       <= POS_W'(CLICK_FRAMES);
			accent_q    <= 1'b0;
			left_q      <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (clicks.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (cmd.beat) begin
							accent_q <= cmd.accent;
							left_q   <= cmd.left;
							pos_q    <= cmd.mute ? POS_W'(CLICK_FRAMES) : '0;
							phase_q  <= '0;
						end else if (cmd.restart) begin
							accent_q <= 1'b0;
							left_q   <= 1'b0;
							pos_q    <= POS_W'(CLICK_FRAMES);
							phase_q  <= '0;
						end
						state_q <= B_LOOK;
					end
				end
				B_LOOK: state_q <= clicking ? B_GAIN : B_DONE;
				B_GAIN: state_q <= B_MAG;
				B_MAG:  state_q <= B_WAIT;
				B_WAIT: begin
					if (div_rsp.done) begin
						phase_q <= phase_q + div_rsp.quotient[31:0];
						pos_q   <= pos_q + 1'b1;
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			beat_q  <= cmd.beat;
			total_q <= cmd.beat_total;
		end
		if (state_q == B_LOOK) begin
			env_q    <= ENV_TBL[pos_q[ENV_AW-1:0]];
			smag_q   <= smag_c;
			neg_q    <= sidx[SINE_TABLE_BITS-1];
			result_q <= '0;
		end
		if (state_q == B_GAIN) begin
			gain_q <= gain_full[44:15];
		end
		if (state_q == B_MAG) begin
			mag_q <= mag_full[44:30];
		end
		if ((state_q == B_WAIT) && div_rsp.done) begin
			result_q <= neg_q ? $signed(16'd0 - mag_ext) : $signed(mag_ext);
		end
		if (load_out) begin
			out_sample_q <= result_q;
			out_beat_q   <= beat_q;
			out_total_q  <= total_q;
		end
	end

	assign clicks.valid        = out_valid_q;
	assign clicks.sample       = out_sample_q;
	assign clicks.beat_started = out_beat_q;
	assign clicks.beat_total   = out_total_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= POS_W'(CLICK_FRAMES))
		else $error("click position ran past the end of the click");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WAIT) && div_rsp.done |=> pos_q == $past(pos_q) + 1'b1)
		else $error("click position did not advance after a sounding frame");
`endif
endmodule

// ===== design/metronome_click_sequencer.sv =====
// Metronome click sequencer top level: configuration registers, front end, queue and click generator.
// Each frame transaction on frames yields exactly one transaction on clicks carrying the
// Q1.15 click sample, a beat flag and the running beat count. For a frame that starts a beat
// the front end runs two serial divisions in turn (step index modulo step count, then the
// beat period), or only the period division with a step count of zero. While a click sounds
// the click generator runs a serial division for the tone phase increment. A four-entry queue
// lets the front end run ahead of the generator. Configuration writes saturate tempo, rate
// and step count into range and must only be issued while no frame is in flight.
module metronome_click_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	mcs_frame_if.sink   frames,
	mcs_click_if.source clicks,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);
	import mcs_pkg::*;

	logic [8:0]  bpm_q;
	logic [17:0] rate_q;
	logic [47:0] pattern_q;
	logic [4:0]  count_q;

	logic        queue_room;
	logic        queue_avail;
	logic        push;
	logic        pop;
	click_cmd_t  push_cmd;
	click_cmd_t  pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpm_q     <= 9'd120;
			rate_q    <= 18'd48000;
			pattern_q <= 48'd1;
			count_q   <= 5'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BPM: begin
					if (cfg_data[8:0] < BPM_MIN) begin
						bpm_q <= BPM_MIN;
					end else if (cfg_data[8:0] > BPM_MAX) begin
						bpm_q <= BPM_MAX;
					end else begin
						bpm_q <= cfg_data[8:0];
					end
				end
				REG_RATE: begin
					if (cfg_data[17:0] < RATE_MIN) begin
						rate_q <= RATE_MIN;
					end else if (cfg_data[17:0] > RATE_MAX) begin
						rate_q <= RATE_MAX;
					end else begin
						rate_q <= cfg_data[17:0];
					end
				end
				REG_PATTERN: pattern_q <= cfg_data;
				REG_COUNT: begin
					count_q <= (cfg_data[4:0] > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : cfg_data[4:0];
				end
				default: ;
			endcase
		end
	end

	mcs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.frames           (frames),
		.beats_per_minute (bpm_q),
		.sample_rate      (rate_q),
		.step_pattern     (pattern_q),
		.step_count       (count_q),
		.queue_room       (queue_room),
		.push             (push),
		.cmd              (push_cmd)
	);

	mcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.room     (queue_room),
		.avail    (queue_avail)
	);

	mcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_rate (rate_q),
		.cmd_valid   (queue_avail),
		.cmd         (pop_cmd),
		.pop         (pop),
		.clicks      (clicks)
	);
endmodule

// ===== test/tb_metronome_click_sequencer.sv =====
// Self-checking testbench of the metronome click sequencer: frame stimulus, click prediction and checks.
module tb_metronome_click_sequencer;
	timeunit 1ns;
	timeprecision 1ps;
	import mcs_pkg::*;

	typedef struct {
		logic signed [15:0] sample;
		logic               beat_started;
		logic [31:0]        beat_total;
	} click_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;

	mcs_frame_if frames ();
	mcs_click_if clicks ();

	metronome_click_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frames    (frames.sink),
		.clicks    (clicks.source),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predicted configuration and run state.
	logic [8:0]  tempo;
	logic [17:0] rate;
	logic [47:0] pattern;
	logic [4:0]  steps_used;
	logic [39:0] frame_ctr;
	logic [55:0] beat_due;
	logic [31:0] step_ctr;
	logic [11:0] click_pos;
	logic        accented;
	logic        left_hand;
	logic [31:0] phase;
	logic [31:0] beat_ctr;

	logic   frame_queue[$];
	click_t expected_clicks[$];
	int     errors;
	int     frames_sent;
	int     idle_mode;
	bit     hold_request;
	int     hold_left;
	bit     hold_used;
	bit     frame_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
		errors++;
	endtask

	function automatic logic [63:0] quarter_wave(input logic [63:0] k);
		logic [63:0] t, t2, b, r;
		t  = (k * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
		t2 = (t * t) >> 30;
		b  = Q30_ONE - t2 / 72;
		b  = Q30_ONE - (((t2 / 42) * b) >> 30);
		b  = Q30_ONE - (((t2 / 20) * b) >> 30);
		b  = Q30_ONE - (((t2 / 6) * b) >> 30);
		r  = ((((t * b) >> 30) * 64'd32767) + (64'd1 << 29)) >> 30;
		return (r > 64'd32767) ? 64'd32767 : r;
	endfunction

	function automatic logic [63:0] decay(input logic [63:0] n);
		logic [63:0] num, ip, f, b;
		num = 64'd7 * n;
		ip  = num / CLICK_FRAMES;
		f   = ((num % CLICK_FRAMES) << 30) / CLICK_FRAMES;
		b   = Q30_ONE;
		for (int d = 10; d >= 1; d--) begin
			b = Q30_ONE - ((f * b) >> 30) / d;
		end
		if (ip > 6) begin
			ip = 6;
		end
		return (b * EXP_INT_Q30[ip]) >> 30;
	endfunction

	function automatic click_t predict_click(input logic restart);
		click_t      c;
		logic [55:0] lag;
		logic [2:0]  code;
		logic [63:0] freq, amp, gain, mag, k;
		logic [9:0]  idx;
		if (restart) begin
			frame_ctr = '0;
			beat_due  = '0;
			step_ctr  = '0;
			click_pos = CLICK_FRAMES;
			accented  = 1'b0;
			left_hand = 1'b0;
			phase     = '0;
			beat_ctr  = '0;
		end
		c.sample       = '0;
		c.beat_started = 1'b0;
		lag = {frame_ctr, 16'd0} - beat_due;
		if (!lag[55]) begin
			code = '0;
			if (steps_used != 0) begin
				code = 3'(pattern >> (3 * (step_ctr % steps_used)));
			end
			c.beat_started = 1'b1;
			beat_ctr++;
			step_ctr++;
			accented  = (code[1:0] == KIND_ACCENT);
			left_hand = code[2];
			click_pos = (code[1:0] == KIND_MUTE) ? 12'(CLICK_FRAMES) : 12'd0;
			phase     = '0;
			beat_due  = beat_due + 56'(((64'(rate) * 60) << 16) / tempo);
		end
		if (click_pos < CLICK_FRAMES) begin
			freq = left_hand ? FREQ_LEFT : FREQ_RIGHT;
			if (accented) begin
				freq += FREQ_ACCENT;
			end
			amp  = accented ? AMP_ACCENT : AMP_NORMAL;
			gain = (amp * decay(click_pos)) >> 15;
			idx  = phase[31:22];
			k    = idx[7:0];
			if (idx[8]) begin
				k = 256 - k;
			end
			mag = (quarter_wave(k) * gain + (64'd1 << 29)) >> 30;
			c.sample = idx[9] ? -16'(mag) : 16'(mag);
			phase += 32'(((freq << 32) + rate / 2) / rate);
			click_pos++;
		end
		frame_ctr++;
		c.beat_total = beat_ctr;
		return c;
	endfunction

	task automatic write_register(input reg_index_t idx, input logic [47:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_BPM: tempo = (value[8:0] < BPM_MIN) ? BPM_MIN :
				(value[8:0] > BPM_MAX) ? BPM_MAX : value[8:0];
			REG_RATE: rate = (value[17:0] < RATE_MIN) ? RATE_MIN :
				(value[17:0] > RATE_MAX) ? RATE_MAX : value[17:0];
			REG_PATTERN: pattern = value;
			REG_COUNT: steps_used = (value[4:0] > MAX_STEPS) ? 5'(MAX_STEPS) : value[4:0];
		endcase
	endtask

	// Waits until the block has drained, then lets its worst beat latency pass.
	task automatic drain();
		wait (frame_queue.size() == 0 && expected_clicks.size() == 0 && !frames.valid);
		repeat (200) @(negedge clk);
	endtask

	// Input side: frame transactions are predicted at the edge that accepts them.
	always @(posedge clk) begin
		frame_taken <= frames.valid && frames.ready;
		if (frames.valid && frames.ready) begin
			expected_clicks.push_back(predict_click(frames.restart));
			frames_sent++;
		end
	end

	// A new frame is offered only once the previous one was taken at the last edge.
	always @(negedge clk) begin
		if (arst_n && (!frames.valid || frame_taken)) begin
			if (frame_queue.size() != 0 &&
			    !(idle_mode == 0 && $urandom_range(99) < 16) &&
			    !(idle_mode == 1 && $urandom_range(99) < 55)) begin
				frames.valid   <= 1'b1;
				frames.restart <= frame_queue.pop_front();
			end else begin
				frames.valid <= 1'b0;
			end
		end
	end

	// The long receiver hold-off is timed here, on its own.
	always @(posedge clk) begin
		if (hold_request && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= 600;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			clicks.ready <= 1'b0;
		end else if (idle_mode == 0) begin
			clicks.ready <= ($urandom_range(99) >= 55);
		end else if (idle_mode == 1) begin
			clicks.ready <= ($urandom_range(99) >= 16);
		end else begin
			clicks.ready <= 1'b1;
		end
	end

	// Output side: every click transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		click_t want;
		if (clicks.valid && clicks.ready) begin
			if (expected_clicks.size() == 0) begin
				report_mismatch("unexpected click transaction", clicks.beat_total, -1);
			end else begin
				want = expected_clicks.pop_front();
				if (clicks.sample !== want.sample)
					report_mismatch("sample", clicks.sample, want.sample);
				if (clicks.beat_started !== want.beat_started)
					report_mismatch("beat_started", clicks.beat_started, want.beat_started);
				if (clicks.beat_total !== want.beat_total)
					report_mismatch("beat_total", clicks.beat_total, want.beat_total);
			end
		end
	end

	always @(negedge clk) begin
		idle_mode <= (frames_sent < 700) ? 0 : (frames_sent < 1400) ? 1 : 2;
	end

	initial begin
		logic [47:0] value;
		errors         = 0;
		frames_sent    = 0;
		idle_mode      = 0;
		hold_request   = 0;
		hold_left      = 0;
		hold_used      = 0;
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = REG_BPM;
		cfg_data       = '0;
		frames.valid   = 1'b0;
		frames.restart = 1'b0;
		clicks.ready   = 1'b0;
		tempo      = 120;
		rate       = 48000;
		pattern    = 1;
		steps_used = 1;
		void'(predict_click(1'b1));
		frame_ctr = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every step code as the first step, including mute and the spare normal code.
		for (int code = 0; code < 8; code++) begin
			write_register(REG_PATTERN, 48'(code));
			write_register(REG_COUNT, 5'd1);
			frame_queue.push_back(1'b1);
			frame_queue.push_back(1'b0);
			frame_queue.push_back(1'b0);
			drain();
		end

		// Fastest tempo at the lowest rate, long enough to reach the second step.
		write_register(REG_BPM, 9'd511);
		write_register(REG_RATE, 18'd0);
		write_register(REG_PATTERN, 48'o75);
		write_register(REG_COUNT, 5'd2);
		frame_queue.push_back(1'b1);
		for (int i = 0; i < 1604; i++) begin
			frame_queue.push_back(1'b0);
		end
		wait (frames_sent > 300);
		hold_request = 1;
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: value = 0;
				1: value = 48'hFFFF_FFFF_FFFF;
				default: value = {$urandom, $urandom};
			endcase
			write_register(REG_BPM, (p < 2) ? value : 48'($urandom_range(511)));
			write_register(REG_RATE, (p < 2) ? value : 48'($urandom_range(262143)));
			write_register(REG_PATTERN, (p < 2) ? value : {$urandom, $urandom});
			write_register(REG_COUNT, (p < 2) ? value : 48'($urandom_range(31)));
			frame_queue.push_back(1'b1);
			for (int i = 0; i < 3; i++) begin
				frame_queue.push_back($urandom_range(1) == 0);
			end
			drain();
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// ===== files.f =====
design/mcs_pkg.sv
design/mcs_if.sv
design/mcs_div.sv
design/mcs_front.sv
design/mcs_queue.sv
design/mcs_back.sv
design/metronome_click_sequencer.sv
test/tb_metronome_click_sequencer.sv
